FILE: sv/bec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bec_pkg
// Shared widths and item types for the bind extent coalescer.
// ----------------------------------------------------------------------------
package bec_pkg;

    localparam int HANDLE_BITS = 16;
    localparam int OFFSET_BITS = 48;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int COUNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [HANDLE_BITS-1:0] buffer_id;
        logic [HANDLE_BITS-1:0] memory_id;
        logic [OFFSET_BITS-1:0] resource_offset;
        logic [OFFSET_BITS-1:0] extent_size;
        logic [OFFSET_BITS-1:0] memory_offset;
        logic                   last_in;
    } extent_in_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] out_buffer_id;
        logic [HANDLE_BITS-1:0] out_memory_id;
        logic [OFFSET_BITS-1:0] out_resource_offset;
        logic [OFFSET_BITS-1:0] out_size;
        logic [OFFSET_BITS-1:0] out_memory_offset;
        logic                   last_out;
    } extent_out_t;

    typedef struct packed {
        logic        push_first;
        logic        push_second;
        extent_out_t first;
        extent_out_t second;
    } push_t;

endpackage
`default_nettype wire

FILE: sv/bind_extent_coalescer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bind_extent_coalescer
// Merges contiguous memory-bind extents into larger ones.
// ----------------------------------------------------------------------------
// One extent item is taken per cycle whenever the four-entry result queue has
// two free slots; the join decision against the single pending extent is made
// in the accepting cycle, and results leave the queue one per cycle while
// merged_ready is high. An item gives zero, one or two results, but every
// extent leaves in at most one result, so with merged_ready held high the
// queue never holds more than two and the input runs at one item per cycle;
// only merged_ready stalls it. Results are registered and leave in push order.
module bind_extent_coalescer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 extent_valid,
    output logic                      extent_ready,
    input  wire bec_pkg::extent_in_t  extent,
    output logic                      merged_valid,
    input  wire logic                 merged_ready,
    output bec_pkg::extent_out_t      merged
);
    import bec_pkg::*;

    push_t push;
    logic  accept;
    logic  room;

    assign extent_ready = room;
    assign accept       = extent_valid && room;

    bec_merge u_merge (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (extent),
        .push   (push)
    );

    bec_out_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .merged_valid (merged_valid),
        .merged_ready (merged_ready),
        .merged       (merged)
    );

endmodule
`default_nettype wire

FILE: sv/bec_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bec_merge
// Holds the pending extent, joins contiguous extents and produces up to two
// results for each accepted item.
// ----------------------------------------------------------------------------
module bec_merge (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire bec_pkg::extent_in_t item,
    output bec_pkg::push_t          push
);
    import bec_pkg::*;

    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    logic [HANDLE_BITS-1:0] pend_buffer_reg;
    logic [HANDLE_BITS-1:0] pend_memory_reg;
    logic [OFFSET_BITS-1:0] pend_res_reg;
    logic [OFFSET_BITS-1:0] pend_len_reg;
    logic [OFFSET_BITS-1:0] pend_mem_reg;
    logic [HANDLE_BITS-1:0] pend_buffer_next;
    logic [HANDLE_BITS-1:0] pend_memory_next;
    logic [OFFSET_BITS-1:0] pend_res_next;
    logic [OFFSET_BITS-1:0] pend_len_next;
    logic [OFFSET_BITS-1:0] pend_mem_next;

    logic [OFFSET_BITS:0] res_end;
    logic [OFFSET_BITS:0] mem_end;
    logic [OFFSET_BITS:0] grown;
    logic                 joins;

    always_comb
    begin
        res_end = {1'b0, pend_res_reg} + {1'b0, pend_len_reg};
        mem_end = {1'b0, pend_mem_reg} + {1'b0, pend_len_reg};
        grown   = {1'b0, pend_len_reg} + {1'b0, item.extent_size};
        joins   = pend_valid_reg
                  && (pend_buffer_reg == item.buffer_id)
                  && (pend_memory_reg == item.memory_id)
                  && (res_end == {1'b0, item.resource_offset})
                  && (mem_end == {1'b0, item.memory_offset})
                  && !grown[OFFSET_BITS];

        if (joins)
        begin
            pend_buffer_next = pend_buffer_reg;
            pend_memory_next = pend_memory_reg;
            pend_res_next    = pend_res_reg;
            pend_len_next    = grown[OFFSET_BITS-1:0];
            pend_mem_next    = pend_mem_reg;
        end
        else
        begin
            pend_buffer_next = item.buffer_id;
            pend_memory_next = item.memory_id;
            pend_res_next    = item.resource_offset;
            pend_len_next    = item.extent_size;
            pend_mem_next    = item.memory_offset;
        end

        pend_valid_next = pend_valid_reg;
        if (accept)
        begin
            pend_valid_next = !item.last_in;
        end

        push.push_first  = accept && pend_valid_reg && !joins;
        push.push_second = accept && item.last_in;

        push.first.out_buffer_id       = pend_buffer_reg;
        push.first.out_memory_id       = pend_memory_reg;
        push.first.out_resource_offset = pend_res_reg;
        push.first.out_size            = pend_len_reg;
        push.first.out_memory_offset   = pend_mem_reg;
        push.first.last_out            = 1'b0;

        push.second.out_buffer_id       = pend_buffer_next;
        push.second.out_memory_id       = pend_memory_next;
        push.second.out_resource_offset = pend_res_next;
        push.second.out_size            = pend_len_next;
        push.second.out_memory_offset   = pend_mem_next;
        push.second.last_out            = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_buffer_reg <= pend_buffer_next;
            pend_memory_reg <= pend_memory_next;
            pend_res_reg    <= pend_res_next;
            pend_len_reg    <= pend_len_next;
            pend_mem_reg    <= pend_mem_next;
        end
    end

    // a last item always leaves nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last_in |=> !pend_valid_reg)
        else $error("pending extent survived a last item");

    // the first result only flushes a pending extent
    assert property (@(posedge clk) disable iff (!rst_n)
        push.push_first |-> pend_valid_reg)
        else $error("flush without pending extent");

endmodule
`default_nettype wire

FILE: sv/bec_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bec_out_fifo
// Small result queue taking up to two items per cycle, giving one on ready.
// ----------------------------------------------------------------------------
module bec_out_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bec_pkg::push_t       push,
    output logic                      room,
    output logic                      merged_valid,
    input  wire logic                 merged_ready,
    output bec_pkg::extent_out_t      merged
);
    import bec_pkg::*;

    extent_out_t           mem_reg [FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] push_count;
    logic                  pop;
    logic [PTR_BITS-1:0]   wr_ptr_plus;

    always_comb
    begin
        pop          = merged_valid && merged_ready;
        push_count   = COUNT_BITS'(push.push_first) + COUNT_BITS'(push.push_second);
        wr_ptr_plus  = wr_ptr_reg + PTR_BITS'(1);
        wr_ptr_next  = wr_ptr_reg + push_count[PTR_BITS-1:0];
        rd_ptr_next  = rd_ptr_reg + PTR_BITS'(pop);
        count_next   = count_reg + push_count - COUNT_BITS'(pop);
        room         = count_reg <= COUNT_BITS'(FIFO_DEPTH - 2);
        merged_valid = count_reg != '0;
        merged       = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push_first)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
            if (push.push_second)
            begin
                mem_reg[wr_ptr_plus] <= push.second;
            end
        end
        else if (push.push_second)
        begin
            mem_reg[wr_ptr_reg] <= push.second;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(FIFO_DEPTH))
        else $error("result queue overflow");

    // pushes only arrive while two slots are free
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.push_first || push.push_second) |-> room)
        else $error("push into a full result queue");

endmodule
`default_nettype wire
